[rtl/stms_pkg.sv]
`timescale 1ns / 1ps

package stms_pkg;

    typedef logic [7:0] angle_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_MAP,
        ST_EMIT
    } state_t;

    localparam int unsigned SERVOS    = 4;
    localparam int unsigned CFG_REGS  = 2 * SERVOS;
    localparam int unsigned RAW_FULL  = 1023;
    localparam int unsigned SLEW_STEP = 3;
    localparam int unsigned ANGLE_MAX = 180;
    localparam int unsigned QUO_BITS  = 8;
    localparam int unsigned REM_BITS  = 18;

    // servo number of the claw, which gets no slewing
    localparam logic [2:0] CLAW_ID = 3'd4;

    localparam angle_t LO_RESET  [SERVOS] = '{8'd40,  8'd100, 8'd10,  8'd25};
    localparam angle_t HI_RESET  [SERVOS] = '{8'd160, 8'd150, 8'd160, 8'd52};
    localparam angle_t POS_RESET [SERVOS] = '{8'd160, 8'd100, 8'd75,  8'd27};

endpackage

[rtl/servo_target_map_and_slew_core.sv]
`timescale 1ns / 1ps

// Servo target mapping with slew limiting.
// Input channel (s_*): one beat carries a servo number (1..4) and a raw 10-bit
// command. Beats with any other servo number are taken and dropped.
// The command is mapped into the servo's range from the config registers:
// target = raw*(hi-lo)/1023 + lo, truncated toward zero, capped at 180.
// Servos 1..3 step from their stored position toward the target by 3 degrees;
// each step is one beat on the result channel (m_*), m_run_end marks the last.
// Servo 4 (claw) gets one beat with the target.
// The input beat passes three steps (multiply, divide-by-1023, map) before the
// first result, then one result per cycle while m_ready is high. One
// command at a time: s_ready is low from acceptance until the last result
// beat is taken. A dropped beat leaves the block idle with s_ready high.
// A stalled receiver holds the result beat.
// Config port (cfg_*): always ready, index 0..7 = left/right/base/grip
// low/high; indices 8..15 are ignored. Write only while idle.
// Reset (aresetn low, synchronous) restores default ranges and positions
// 160, 100, 75, 27 and returns to idle.

module servo_target_map_and_slew_core (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [3:0] s_servo_select,
    input  logic [9:0] s_raw_command,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_servo_id,
    output logic [7:0] m_angle_out,
    output logic       m_run_end,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_index,
    input  logic [7:0] cfg_data
);

    stms_pkg::state_t state_reg, state_next;

    stms_pkg::angle_t lo_reg  [stms_pkg::SERVOS];
    stms_pkg::angle_t hi_reg  [stms_pkg::SERVOS];
    stms_pkg::angle_t cur_reg [stms_pkg::SERVOS];

    logic [2:0]                      sel_reg, sel_next;
    logic [9:0]                      raw_reg, raw_next;
    logic                            neg_reg, neg_next;
    logic [stms_pkg::REM_BITS-1:0]   rem_reg, rem_next;
    logic [stms_pkg::QUO_BITS-1:0]   quo_reg, quo_next;
    logic signed [9:0]               pos_reg, pos_next;
    stms_pkg::angle_t                tgt_reg, tgt_next;
    logic                            up_reg, up_next;

    logic [1:0]                      slot;
    logic                            sel_ok;
    logic                            in_beat, out_beat, cfg_beat;
    logic signed [8:0]               diff_s;
    logic signed [19:0]              prod;
    logic [19:0]                     prod_mag;
    logic [stms_pkg::REM_BITS-1:0]   div_sum;
    logic [stms_pkg::QUO_BITS-1:0]   div_quo;
    logic signed [9:0]               quo_s;
    logic signed [9:0]               map_sum;
    stms_pkg::angle_t                map_tgt;
    logic signed [9:0]               tgt_s;
    logic signed [9:0]               pos_up, pos_dn;
    logic                            is_claw;
    logic                            last;

    assign slot    = sel_reg[1:0] - 2'd1;
    assign sel_ok  = s_servo_select inside {[4'd1:4'd4]};
    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;
    assign cfg_beat = cfg_valid && cfg_ready;
    assign is_claw  = (sel_reg == stms_pkg::CLAW_ID);

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            stms_pkg::ST_IDLE: begin
                if (in_beat && sel_ok) state_next = stms_pkg::ST_MUL;
            end
            stms_pkg::ST_MUL:  state_next = stms_pkg::ST_DIV;
            stms_pkg::ST_DIV:  state_next = stms_pkg::ST_MAP;
            stms_pkg::ST_MAP:  state_next = stms_pkg::ST_EMIT;
            stms_pkg::ST_EMIT: begin
                if (out_beat && last) state_next = stms_pkg::ST_IDLE;
            end
            default:           state_next = stms_pkg::ST_IDLE;
        endcase
    end

    // ---------------- handshake outputs ----------------
    always_comb begin
        s_ready   = (state_reg == stms_pkg::ST_IDLE);
        m_valid   = (state_reg == stms_pkg::ST_EMIT);
        cfg_ready = 1'b1;
    end

    // ---------------- datapath ----------------
    assign diff_s   = $signed({1'b0, hi_reg[slot]}) - $signed({1'b0, lo_reg[slot]});
    assign prod     = $signed({1'b0, raw_reg}) * diff_s;
    assign prod_mag = prod[19] ? 20'(-prod) : 20'(prod);

    // x / 1023 == (x + (x >> 10) + 1) >> 10 over the whole product range
    assign div_sum = rem_reg
                   + {{(stms_pkg::REM_BITS - 8){1'b0}}, rem_reg[stms_pkg::REM_BITS-1:10]}
                   + {{(stms_pkg::REM_BITS - 1){1'b0}}, 1'b1};
    assign div_quo = div_sum[stms_pkg::REM_BITS-1:10];

    assign quo_s   = neg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg});
    assign map_sum = $signed({2'b00, lo_reg[slot]}) + quo_s;
    always_comb begin
        if (map_sum < 10'sd0)
            map_tgt = '0;
        else if (map_sum > $signed(10'(stms_pkg::ANGLE_MAX)))
            map_tgt = 8'(stms_pkg::ANGLE_MAX);
        else
            map_tgt = map_sum[7:0];
    end

    assign tgt_s  = $signed({2'b00, tgt_reg});
    assign pos_up = pos_reg + $signed(10'(stms_pkg::SLEW_STEP));
    assign pos_dn = pos_reg - $signed(10'(stms_pkg::SLEW_STEP));
    assign last   = is_claw || (up_reg ? (pos_up > tgt_s) : (pos_dn < tgt_s));

    always_comb begin
        sel_next = sel_reg;
        raw_next = raw_reg;
        neg_next = neg_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        pos_next = pos_reg;
        tgt_next = tgt_reg;
        up_next  = up_reg;
        case (state_reg)
            stms_pkg::ST_IDLE: begin
                if (in_beat) begin
                    sel_next = s_servo_select[2:0];
                    raw_next = s_raw_command;
                end
            end
            stms_pkg::ST_MUL: begin
                neg_next = prod[19];
                rem_next = prod_mag[stms_pkg::REM_BITS-1:0];
            end
            stms_pkg::ST_DIV: begin
                quo_next = div_quo;
            end
            stms_pkg::ST_MAP: begin
                tgt_next = map_tgt;
                up_next  = (map_tgt > cur_reg[slot]);
                pos_next = is_claw ? $signed({2'b00, map_tgt})
                                   : $signed({2'b00, cur_reg[slot]});
            end
            stms_pkg::ST_EMIT: begin
                if (out_beat) pos_next = up_reg ? pos_up : pos_dn;
            end
            default: ;
        endcase
    end

    assign m_servo_id  = sel_reg;
    assign m_angle_out = pos_reg[7:0];
    assign m_run_end   = last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stms_pkg::ST_IDLE;
            for (int i = 0; i < stms_pkg::SERVOS; i++) begin
                lo_reg[i]  <= stms_pkg::LO_RESET[i];
                hi_reg[i]  <= stms_pkg::HI_RESET[i];
                cur_reg[i] <= stms_pkg::POS_RESET[i];
            end
        end else begin
            state_reg <= state_next;
            // index bit 3 set means beyond the register list
            if (cfg_beat && !cfg_index[3]) begin
                if (cfg_index[0]) hi_reg[cfg_index[2:1]] <= cfg_data;
                else              lo_reg[cfg_index[2:1]] <= cfg_data;
            end
            if (out_beat && last) cur_reg[slot] <= tgt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        sel_reg <= sel_next;
        raw_reg <= raw_next;
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        pos_reg <= pos_next;
        tgt_reg <= tgt_next;
        up_reg  <= up_next;
    end

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result beat is pending");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_run_end) |=> s_ready)
        else $error("block not idle after last beat of a run");

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_run_end) |=> (m_valid && m_servo_id == $past(m_servo_id)))
        else $error("run broken before its last beat");

    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_angle_out <= 8'(stms_pkg::ANGLE_MAX)))
        else $error("angle above maximum");

    a_claw_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_servo_id == stms_pkg::CLAW_ID) |-> m_run_end)
        else $error("claw run longer than one beat");
`endif

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int STEP          = 3;
    localparam int FULL_SCALE    = 1023;
    localparam int ANGLE_CAP     = 180;
    localparam int REG_SLOTS     = 8;
    localparam int SETTLE_CYCLES = 20;
    localparam int STALL_LIMIT   = 3000;
    localparam int MAX_REPORTS   = 10;

    localparam logic [3:0] SERVO_LEFT  = 4'd1;
    localparam logic [3:0] SERVO_RIGHT = 4'd2;
    localparam logic [3:0] SERVO_BASE  = 4'd3;
    localparam logic [3:0] SERVO_CLAW  = 4'd4;

    typedef enum int {
        REG_LEFT_LOW,
        REG_LEFT_HIGH,
        REG_RIGHT_LOW,
        REG_RIGHT_HIGH,
        REG_BASE_LOW,
        REG_BASE_HIGH,
        REG_GRIP_LOW,
        REG_GRIP_HIGH
    } range_reg_t;

    typedef struct {
        logic [3:0] sel;
        logic [9:0] raw;
    } servo_cmd_t;

    typedef struct {
        logic [2:0]       id;
        stms_pkg::angle_t angle;
        logic             last;
    } servo_move_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [3:0] s_servo_select = '0;
    logic [9:0] s_raw_command = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_servo_id;
    logic [7:0] m_angle_out;
    logic       m_run_end;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [3:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    servo_cmd_t  pending_cmds[$];
    servo_move_t expected_moves[$];
    servo_cmd_t  next_cmd;

    stms_pkg::angle_t range_lo[stms_pkg::SERVOS];
    stms_pkg::angle_t range_hi[stms_pkg::SERVOS];
    stms_pkg::angle_t pos_mirror[stms_pkg::SERVOS];

    int  idle_pct = 25;
    int  cmds_queued = 0;
    int  in_beats = 0;
    int  move_beats = 0;
    int  cfg_beats = 0;
    int  fail_count = 0;
    int  stall_cycles = 0;
    bit  s_took = 1'b0;

    servo_target_map_and_slew_core i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_servo_select (s_servo_select),
        .s_raw_command  (s_raw_command),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_servo_id     (m_servo_id),
        .m_angle_out    (m_angle_out),
        .m_run_end      (m_run_end),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Expected position beats for one command, updates the stored position.
    function automatic void predict_moves(input logic [3:0] sel, input logic [9:0] raw);
        int slot;
        int lo;
        int hi;
        int tgt;
        int pos;
        servo_move_t mv;
        if (!(sel inside {[SERVO_LEFT:SERVO_CLAW]}))
            return;
        slot = int'(sel) - 1;
        lo = int'(range_lo[slot]);
        hi = int'(range_hi[slot]);
        tgt = (int'(raw) * (hi - lo)) / FULL_SCALE + lo;
        if (tgt > ANGLE_CAP)
            tgt = ANGLE_CAP;
        if (tgt < 0)
            tgt = 0;
        mv.id = sel[2:0];
        if (sel == SERVO_CLAW) begin
            mv.angle = tgt[7:0];
            mv.last = 1'b1;
            expected_moves.push_back(mv);
        end else begin
            pos = int'(pos_mirror[slot]);
            if (tgt > pos) begin
                while (pos <= tgt) begin
                    mv.angle = pos[7:0];
                    mv.last = (pos + STEP > tgt);
                    expected_moves.push_back(mv);
                    pos += STEP;
                end
            end else begin
                while (pos >= tgt) begin
                    mv.angle = pos[7:0];
                    mv.last = (pos - STEP < tgt);
                    expected_moves.push_back(mv);
                    pos -= STEP;
                end
            end
        end
        pos_mirror[slot] = tgt[7:0];
    endfunction

    // input beats
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_servo_select <= '0;
            s_raw_command <= '0;
        end else if (!s_valid || s_took) begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                next_cmd = pending_cmds.pop_front();
                s_valid <= 1'b1;
                s_servo_select <= next_cmd.sel;
                s_raw_command <= next_cmd.raw;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(0, 99) >= idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_took = 1'b0;
            range_lo = '{8'd40, 8'd100, 8'd10, 8'd25};
            range_hi = '{8'd160, 8'd150, 8'd160, 8'd52};
            pos_mirror = '{8'd160, 8'd100, 8'd75, 8'd27};
        end else begin
            if (m_valid && m_ready) begin
                move_beats++;
                if (expected_moves.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected result beat id=%0d angle=%0d end=%0b",
                                 $realtime, m_servo_id, m_angle_out, m_run_end);
                end else begin
                    servo_move_t want;
                    want = expected_moves.pop_front();
                    if (m_servo_id !== want.id || m_angle_out !== want.angle ||
                        m_run_end !== want.last) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: mismatch id/angle/end exp %0d/%0d/%0b got %0d/%0d/%0b",
                                     $realtime, want.id, want.angle, want.last,
                                     m_servo_id, m_angle_out, m_run_end);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                cfg_beats++;
                if (cfg_index < REG_SLOTS) begin
                    if (cfg_index[0])
                        range_hi[cfg_index[2:1]] = cfg_data;
                    else
                        range_lo[cfg_index[2:1]] = cfg_data;
                end
            end
            s_took = s_valid && s_ready;
            if (s_took) begin
                in_beats++;
                predict_moves(s_servo_select, s_raw_command);
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles, %0d beats still expected",
                         $realtime, STALL_LIMIT, expected_moves.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic queue_cmd(input logic [3:0] sel, input logic [9:0] raw);
        servo_cmd_t c;
        c.sel = sel;
        c.raw = raw;
        pending_cmds.push_back(c);
        cmds_queued++;
    endtask

    task automatic write_reg(input int idx, input int value);
        int want;
        want = cfg_beats + 1;
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx[3:0];
        cfg_data <= value[7:0];
        @(negedge aclk);
        while (cfg_beats != want)
            @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_range(input logic [3:0] servo, input int lo, input int hi);
        write_reg(REG_LEFT_LOW + 2 * (int'(servo) - 1), lo);
        write_reg(REG_LEFT_HIGH + 2 * (int'(servo) - 1), hi);
    endtask

    // block idle: every command taken, every beat seen, plus latency margin
    task automatic wait_idle();
        while (in_beats != cmds_queued || expected_moves.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        logic [3:0] sel;
        logic [9:0] raw;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // default ranges: long runs both ways, equal target, claw, unused selectors
        queue_cmd(SERVO_LEFT, 10'd0);
        queue_cmd(SERVO_LEFT, 10'd1023);
        queue_cmd(SERVO_LEFT, 10'd1023);
        queue_cmd(SERVO_RIGHT, 10'h155);
        queue_cmd(SERVO_BASE, 10'd0);
        queue_cmd(SERVO_BASE, 10'h2AA);
        queue_cmd(SERVO_CLAW, 10'd0);
        queue_cmd(SERVO_CLAW, 10'd1023);
        queue_cmd(4'd0, 10'h3FF);
        queue_cmd(4'd5, 10'd0);
        queue_cmd(4'd9, 10'h2AA);
        queue_cmd(4'd15, 10'h155);
        wait_idle();

        // full 0..180 span: 61-beat runs up and down
        for (int s = 1; s <= stms_pkg::SERVOS; s++)
            set_range(s[3:0], 0, ANGLE_CAP);
        queue_cmd(SERVO_LEFT, 10'd0);
        queue_cmd(SERVO_LEFT, 10'd1023);
        queue_cmd(SERVO_RIGHT, 10'd1023);
        queue_cmd(SERVO_RIGHT, 10'd0);
        queue_cmd(SERVO_CLAW, 10'd1023);
        wait_idle();

        // reversed ranges, ranges beyond 180 that saturate, ignored indexes
        set_range(SERVO_LEFT, ANGLE_CAP, 0);
        set_range(SERVO_RIGHT, 255, 0);
        set_range(SERVO_BASE, 255, 255);
        set_range(SERVO_CLAW, 0, 255);
        for (int r = REG_SLOTS; r < 16; r++)
            write_reg(r, $urandom_range(0, 255));
        queue_cmd(SERVO_LEFT, 10'd0);
        queue_cmd(SERVO_LEFT, 10'd1023);
        queue_cmd(SERVO_RIGHT, 10'd0);
        queue_cmd(SERVO_BASE, 10'd500);
        queue_cmd(SERVO_CLAW, 10'd1023);
        queue_cmd(SERVO_CLAW, 10'd512);
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            idle_pct = (p == 1) ? 0 : 25;
            for (int r = REG_LEFT_LOW; r <= REG_GRIP_HIGH; r++) begin
                if (p == 3 && $urandom_range(0, 2) == 0)
                    write_reg(r, $urandom_range(ANGLE_CAP + 1, 255));
                else
                    write_reg(r, $urandom_range(0, ANGLE_CAP));
            end
            if ($urandom_range(0, 1) == 1)
                write_reg($urandom_range(REG_SLOTS, 15), $urandom_range(0, 255));
            for (int n = 0; n < 55; n++) begin
                if ($urandom_range(0, 99) < 85)
                    sel = 4'($urandom_range(1, 4));
                else
                    sel = 4'($urandom_range(0, 15));
                case ($urandom_range(0, 9))
                    0: raw = 10'd0;
                    1: raw = 10'd1023;
                    default: raw = 10'($urandom_range(0, 1023));
                endcase
                queue_cmd(sel, raw);
            end
            wait_idle();
        end

        $display("Covered %0d commands, %0d position beats checked, %0d register writes",
                 in_beats, move_beats, cfg_beats);
        $display("Settings included defaults, full span, reversed and saturating ranges");
        if (fail_count == 0 && expected_moves.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d failures, %0d beats never seen", fail_count, expected_moves.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
